// ===== rtl/core/sdpe_pkg.sv =====
// Shared types and constants for the switch debounce / press event block.
// Holds the register map, the state and result records and the reset values.
// No dependencies.
`default_nettype none

package sdpe_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // Register map
  localparam logic [CFG_ADDR_W-1:0] REG_OPEN_VALUE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_RATE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_START   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_WINDOW  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS     = 3'd5;

  // Register reset values
  localparam logic [7:0]  RST_OPEN_VALUE     = 8'd0;
  localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd5;
  localparam logic [7:0]  RST_REPEAT_RATE    = 8'd10;
  localparam logic [15:0] RST_REPEAT_START   = 16'd500;
  localparam logic [15:0] RST_DOUBLE_WINDOW  = 16'd300;
  localparam logic [15:0] RST_LONG_PRESS     = 16'd1000;

  typedef struct packed {
    logic [7:0]  open_value;
    logic [7:0]  debounce_ticks;
    logic [7:0]  repeat_rate;
    logic [15:0] repeat_start_ticks;
    logic [15:0] double_window_ticks;
    logic [15:0] long_press_ticks;
  } sdpe_cfg_t;

  typedef struct packed {
    logic [15:0] ticks;
    logic [7:0]  raw_previous;
    logic [15:0] change_time;
    logic        active;
    logic [7:0]  debounced_value;
    logic [15:0] valid_change_time;
    logic [7:0]  pressed_key;
    logic [15:0] last_press_time;
    logic        double_seen;
    logic [7:0]  presses;
    logic        toggler;
    logic [7:0]  repeat_countdown;
    logic [7:0]  repeats;
    logic        long_held;
    logic [7:0]  releases;
  } sdpe_state_t;

  typedef struct packed {
    logic clear_double;
    logic clear_repeats;
    logic clear_released;
    logic clear_pressed;
  } sdpe_clr_t;

  // Declared high field first so key_code lands in the low bits.
  typedef struct packed {
    logic [15:0] tick_count;
    logic        toggle_flag;
    logic        long_flag;
    logic        double_flag;
    logic [7:0]  press_and_repeat_count;
    logic [7:0]  release_count;
    logic [7:0]  press_count;
    logic [7:0]  key_code;
  } sdpe_result_t;

  localparam int RESULT_W = $bits(sdpe_result_t);

endpackage

`default_nettype wire

// ===== rtl/core/sdpe_step.sv =====
// Next-state logic for one item: on a scan tick, tick, debounce, press/release
// events, long press and auto-repeat; on every item, then the requested clears.
// Depends on sdpe_pkg.
`default_nettype none

module sdpe_step
  import sdpe_pkg::*;
(
  input  sdpe_state_t  st_i,
  input  sdpe_cfg_t    cfg_i,
  input  logic         kind_i,
  input  logic [7:0]   sw_i,
  input  sdpe_clr_t    clr_i,
  output sdpe_state_t  st_o,
  output sdpe_result_t res_o
);

  sdpe_state_t s;
  logic [15:0] t;
  logic [15:0] since_change;
  logic [15:0] since_press;
  logic [7:0]  cd_dec;
  logic        valid_now;

  always_comb begin
    s            = st_i;
    t            = st_i.ticks + 16'd1;
    since_change = 16'd0;
    since_press  = 16'd0;
    cd_dec       = st_i.repeat_countdown - 8'd1;
    valid_now    = 1'b0;

    if (!kind_i) begin
      s.ticks = t;
      if (sw_i != s.raw_previous) begin
        s.raw_previous = sw_i;
        s.change_time  = t;
        s.active       = 1'b1;
      end
      since_change = t - s.change_time;
      if (s.active && (since_change >= {8'd0, cfg_i.debounce_ticks})) begin
        if (sw_i != s.debounced_value) begin
          s.debounced_value   = sw_i;
          s.valid_change_time = t;
        end
        // value became valid on this very tick
        valid_now = (s.valid_change_time == t);
        if (sw_i != cfg_i.open_value) begin
          if (valid_now) begin
            since_press = t - s.last_press_time;
            if ((sw_i == s.pressed_key) && (since_press < cfg_i.double_window_ticks)) begin
              s.double_seen = 1'b1;
            end
            s.last_press_time = t;
            s.pressed_key     = sw_i;
            s.presses         = s.presses + 8'd1;
            s.toggler         = ~s.toggler;
          end
          if (since_change > cfg_i.repeat_start_ticks) begin
            if (cd_dec == 8'd0) begin
              s.repeat_countdown = cfg_i.repeat_rate;
              s.repeats          = s.repeats + 8'd1;
            end else begin
              s.repeat_countdown = cd_dec;
            end
          end
          if (since_change > cfg_i.long_press_ticks) begin
            s.long_held = 1'b1;
          end
        end else begin
          if (valid_now) begin
            s.releases = s.releases + 8'd1;
          end
          s.active    = 1'b0;
          s.long_held = 1'b0;
        end
      end
    end

    res_o.key_code               = s.pressed_key;
    res_o.press_count            = s.presses;
    res_o.release_count          = s.releases;
    res_o.press_and_repeat_count = s.presses + s.repeats;
    res_o.double_flag            = s.double_seen;
    res_o.long_flag              = s.long_held;
    res_o.toggle_flag            = s.toggler;
    res_o.tick_count             = s.ticks;

    // clears act after the result is taken
    st_o = s;
    if (clr_i.clear_pressed || clr_i.clear_repeats) begin
      st_o.presses = 8'd0;
    end
    if (clr_i.clear_repeats) begin
      st_o.repeats = 8'd0;
    end
    if (clr_i.clear_released) begin
      st_o.releases = 8'd0;
    end
    if (clr_i.clear_double) begin
      st_o.double_seen = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/switch_debounce_press_events.sv =====
// Switch debounce and press event tracker: one scan tick per scan transfer.
// Input stream: in_tuser = kind (0 = scan tick with sample, 1 = read only);
//   in_tdata = switch_value, clear_pressed, clear_released, clear_repeats,
//   clear_double (low bit up).
// Output stream: one result per input transfer with key code, counters and
//   flags as they stand after the tick, before the clears in that item.
// The state and the result register update at the edge that accepts the
// item. Throughput is one item per cycle while the receiver does not stall;
// the state update is a single pass of compares and 16-bit subtracts in sdpe_step.
// When the receiver stalls, the result register holds; a new item is taken
// only in a cycle where the held result leaves, so in_tready follows
// out_tready while a result is pending.
// Configuration: cfg_we/cfg_addr/cfg_wdata; the user writes only while idle,
// the block does not enforce it. Writing open_value also reloads the latched
// codes; writing repeat_rate reloads the repeat countdown. Unused addresses are ignored.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// counters and flags; the output is empty afterwards.
`default_nettype none

module switch_debounce_press_events
  import sdpe_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [7:0] switch_value, [8] clear_pressed, [9] clear_released,
  // [10] clear_repeats, [11] clear_double, [15:12] zero
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  // [0] kind
  input  wire                    in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [7:0] key_code, [15:8] press_count, [23:16] release_count,
  // [31:24] press_and_repeat_count, [32] double_flag, [33] long_flag,
  // [34] toggle_flag, [50:35] tick_count, [55:51] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire                    cfg_we,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

  sdpe_cfg_t    cfg_r, cfg_nxt;
  sdpe_state_t  st_r, st_nxt;
  sdpe_state_t  step_st;
  sdpe_result_t step_res;
  sdpe_clr_t    clr;
  logic         out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic         in_fire;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  assign clr.clear_pressed  = in_tdata[8];
  assign clr.clear_released = in_tdata[9];
  assign clr.clear_repeats  = in_tdata[10];
  assign clr.clear_double   = in_tdata[11];

  sdpe_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg_r),
    .kind_i (in_tuser),
    .sw_i   (in_tdata[7:0]),
    .clr_i  (clr),
    .st_o   (step_st),
    .res_o  (step_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    st_nxt  = in_fire ? step_st : st_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_OPEN_VALUE: begin
          cfg_nxt.open_value     = cfg_wdata[7:0];
          st_nxt.raw_previous    = cfg_wdata[7:0];
          st_nxt.debounced_value = cfg_wdata[7:0];
          st_nxt.pressed_key     = cfg_wdata[7:0];
        end
        REG_DEBOUNCE_TICKS: cfg_nxt.debounce_ticks = cfg_wdata[7:0];
        REG_REPEAT_RATE: begin
          cfg_nxt.repeat_rate     = cfg_wdata[7:0];
          st_nxt.repeat_countdown = cfg_wdata[7:0];
        end
        REG_REPEAT_START:  cfg_nxt.repeat_start_ticks  = cfg_wdata;
        REG_DOUBLE_WINDOW: cfg_nxt.double_window_ticks = cfg_wdata;
        REG_LONG_PRESS:    cfg_nxt.long_press_ticks    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_value          <= RST_OPEN_VALUE;
      cfg_r.debounce_ticks      <= RST_DEBOUNCE_TICKS;
      cfg_r.repeat_rate         <= RST_REPEAT_RATE;
      cfg_r.repeat_start_ticks  <= RST_REPEAT_START;
      cfg_r.double_window_ticks <= RST_DOUBLE_WINDOW;
      cfg_r.long_press_ticks    <= RST_LONG_PRESS;
      st_r.ticks                <= 16'd0;
      st_r.raw_previous         <= RST_OPEN_VALUE;
      st_r.change_time          <= 16'd0;
      st_r.active               <= 1'b0;
      st_r.debounced_value      <= RST_OPEN_VALUE;
      st_r.valid_change_time    <= 16'd0;
      st_r.pressed_key          <= RST_OPEN_VALUE;
      st_r.last_press_time      <= 16'd0;
      st_r.double_seen          <= 1'b0;
      st_r.presses              <= 8'd0;
      st_r.toggler              <= 1'b0;
      st_r.repeat_countdown     <= RST_REPEAT_RATE;
      st_r.repeats              <= 8'd0;
      st_r.long_held            <= 1'b0;
      st_r.releases             <= 8'd0;
      out_valid_r               <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      st_r  <= st_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {{(OUT_TDATA_W-RESULT_W){1'b0}}, step_res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tuser) |=> (st_r.ticks == $past(st_r.ticks) + 16'd1))
    else $error("tick count did not advance on scan transfer");

  a_read_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> $stable(st_r.ticks) && $stable(st_r.active))
    else $error("read-only transfer changed tick state");

  a_long_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.long_held |-> st_r.active)
    else $error("long press flagged while inactive");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_tvalid && (out_tdata[50:35] == st_r.ticks)))
    else $error("result tick count does not match state");
`endif

endmodule

`default_nettype wire
